/* src/ufp_pkg.sv */
// ----------------------------------------------------------------------------
// ufp_pkg: shared types and constants of the form body parser
// Result kinds, separator and escape characters, and the bundle of results
// that one body word produces.
// ----------------------------------------------------------------------------
`default_nettype none

package ufp_pkg;

  localparam logic [1:0] KIND_KEY = 2'd0;
  localparam logic [1:0] KIND_VAL = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic [1:0]              cnt;
    res_t [MAX_RES-1:0]      slot;
  } bundle_t;

endpackage

`default_nettype wire

/* src/urlencoded_form_parser_top.sv */
// ----------------------------------------------------------------------------
// urlencoded_form_parser_top: form body parser
// Input side: push a body word (in_func low, in_byte) or an end-of-body word
// (in_func high) while in_full is low. Output side: while out_empty is low,
// out_kind, out_byte and out_last show the oldest decoded word; pop takes it.
// Each input word yields zero to three output words, out_last marking the
// final one. The classifier takes one input word per cycle while in_full
// is low and places its results as one bundle in a queue of QUEUE_DEPTH
// bundles; the serializer drains one output word per cycle while out_pop
// is high. Results are registered in the queue before they show. Sustained
// rate is one input word per cycle while each word yields at most one
// result; words yielding two or three results need one pop each. When the
// receiver stalls, the queue fills and in_full rises; no word is lost.
// Reset synchronously clears the parser state and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module urlencoded_form_parser_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic       in_func,
  input  wire logic [7:0] in_byte,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  ufp_pkg::bundle_t fr_bundle;
  ufp_pkg::bundle_t head;
  logic             fr_vld;
  logic             acc;
  logic             deq;
  logic             q_empty;

  assign acc       = in_push && !in_full;
  assign out_empty = q_empty;

  ufp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .func       (in_func),
    .byte_in    (in_byte),
    .bundle     (fr_bundle),
    .bundle_vld (fr_vld)
  );

  ufp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (fr_vld),
    .wr_data (fr_bundle),
    .rd      (deq),
    .rd_data (head),
    .q_full  (in_full),
    .q_empty (q_empty)
  );

  ufp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .head_vld (!q_empty),
    .pop      (out_pop),
    .deq      (deq),
    .kind     (out_kind),
    .data     (out_byte),
    .last     (out_last)
  );

  a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fr_vld |-> (fr_bundle.cnt != 2'd0))
    else $error("empty bundle written to queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fr_vld |-> !in_full)
    else $error("bundle written to full queue");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_kind == ufp_pkg::KIND_KEY || out_kind == ufp_pkg::KIND_VAL ||
                    out_kind == ufp_pkg::KIND_END))
    else $error("illegal result kind");

  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == ufp_pkg::KIND_END) |-> (out_byte == 8'h00))
    else $error("pair end word carries data");

endmodule

`default_nettype wire

/* src/ufp_front.sv */
// ----------------------------------------------------------------------------
// ufp_front: byte classifier and parser state
// Decodes one body word per cycle while acc is high into a bundle of up to
// three results and keeps the key/value, pair and escape state.
// ----------------------------------------------------------------------------
`default_nettype none

module ufp_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc,
  input  wire logic             func,
  input  wire logic [7:0]       byte_in,
  output ufp_pkg::bundle_t      bundle,
  output logic                  bundle_vld
);

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HEX  = 2'd2;

  logic       iv_r, iv_nxt;
  logic       ks_r, ks_nxt;
  logic [1:0] esc_r, esc_nxt;
  logic [7:0] held_r, held_nxt;

  ufp_pkg::res_t [ufp_pkg::MAX_RES-1:0] slots;
  logic [1:0]                           n;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  always_comb begin
    logic [4:0] hb;
    logic [4:0] hh;
    logic [1:0] dk;
    logic       do_plain;
    logic       sep;
    hb       = hex_val(byte_in);
    hh       = hex_val(held_r);
    dk       = iv_r ? ufp_pkg::KIND_VAL : ufp_pkg::KIND_KEY;
    do_plain = 1'b0;
    sep      = (byte_in == ufp_pkg::CH_AMP) || (byte_in == ufp_pkg::CH_SEMI);
    iv_nxt   = iv_r;
    ks_nxt   = ks_r;
    esc_nxt  = esc_r;
    held_nxt = held_r;
    slots    = '0;
    n        = 2'd0;
    if (func) begin
      if (esc_r == ESC_PCT) begin
        slots[n] = '{dk, ufp_pkg::CH_PCT};
        n = n + 2'd1;
      end else if (esc_r == ESC_HEX) begin
        slots[n] = '{dk, ufp_pkg::CH_PCT};
        n = n + 2'd1;
        slots[n] = '{dk, held_r};
        n = n + 2'd1;
      end
      if (ks_r) begin
        slots[n] = '{ufp_pkg::KIND_END, 8'h00};
        n = n + 2'd1;
      end
      iv_nxt   = 1'b0;
      ks_nxt   = 1'b0;
      esc_nxt  = ESC_NONE;
      held_nxt = 8'h00;
    end else if (esc_r == ESC_PCT) begin
      if (hb[4]) begin
        held_nxt = byte_in;
        esc_nxt  = ESC_HEX;
      end else begin
        esc_nxt  = ESC_NONE;
        slots[n] = '{dk, ufp_pkg::CH_PCT};
        n = n + 2'd1;
        do_plain = 1'b1;
      end
    end else if (esc_r == ESC_HEX) begin
      esc_nxt  = ESC_NONE;
      held_nxt = 8'h00;
      if (hb[4] && hh[4]) begin
        slots[n] = '{dk, {hh[3:0], hb[3:0]}};
        n = n + 2'd1;
      end else begin
        slots[n] = '{dk, ufp_pkg::CH_PCT};
        n = n + 2'd1;
        slots[n] = '{dk, held_r};
        n = n + 2'd1;
        do_plain = 1'b1;
      end
    end else begin
      esc_nxt  = ESC_NONE;
      do_plain = 1'b1;
    end
    if (do_plain && (ks_r || !sep)) begin
      ks_nxt = 1'b1;
      if (sep) begin
        slots[n] = '{ufp_pkg::KIND_END, 8'h00};
        n = n + 2'd1;
        iv_nxt = 1'b0;
        ks_nxt = 1'b0;
      end else if (byte_in == ufp_pkg::CH_EQ && !iv_r) begin
        iv_nxt = 1'b1;
      end else if (byte_in == ufp_pkg::CH_PLUS) begin
        slots[n] = '{dk, ufp_pkg::CH_SPACE};
        n = n + 2'd1;
      end else if (byte_in == ufp_pkg::CH_PCT) begin
        esc_nxt = ESC_PCT;
      end else begin
        slots[n] = '{dk, byte_in};
        n = n + 2'd1;
      end
    end
  end

  assign bundle     = '{cnt: n, slot: slots};
  assign bundle_vld = acc && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r   <= 1'b0;
      ks_r   <= 1'b0;
      esc_r  <= ESC_NONE;
      held_r <= 8'h00;
    end else if (acc) begin
      iv_r   <= iv_nxt;
      ks_r   <= ks_nxt;
      esc_r  <= esc_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/ufp_queue.sv */
// ----------------------------------------------------------------------------
// ufp_queue: bundle queue between classifier and output stage
// A small register queue of result bundles with occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module ufp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr,
  input  wire ufp_pkg::bundle_t wr_data,
  input  wire logic             rd,
  output ufp_pkg::bundle_t      rd_data,
  output logic                  q_full,
  output logic                  q_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ufp_pkg::bundle_t mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;

  assign q_full  = (cnt_r == CNT_W'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
      end
      if (rd) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
      end
      if (wr && !rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (rd && !wr) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* src/ufp_back.sv */
// ----------------------------------------------------------------------------
// ufp_back: result serializer
// Presents the results of the oldest bundle one word at a time and marks
// the final one of each bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module ufp_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ufp_pkg::bundle_t head,
  input  wire logic             head_vld,
  input  wire logic             pop,
  output logic                  deq,
  output logic [1:0]            kind,
  output logic [7:0]            data,
  output logic                  last
);

  logic [1:0] sel_r;
  logic       take;

  assign take = pop && head_vld;
  assign last = (sel_r == head.cnt - 2'd1);
  assign deq  = take && last;
  assign kind = head.slot[sel_r].kind;
  assign data = head.slot[sel_r].data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 2'd0;
    end else if (take) begin
      sel_r <= last ? 2'd0 : sel_r + 2'd1;
    end
  end

endmodule

`default_nettype wire

/* verif/form_parse_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_parse_checker: scoreboard for the form body parser
// Watches both queue interfaces. Every accepted input word runs through a
// local decoder of the form body grammar, and the words it yields are queued
// in order. Every popped output word is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module form_parse_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  logic       in_func,
  input  logic [7:0] in_byte,
  input  logic       out_empty,
  input  logic       out_pop,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  output int         fail_count,
  output int         words_waiting
);

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } out_word_t;

  out_word_t     expected_words[$];
  ufp_pkg::res_t step_words[$];
  logic          in_value;
  logic          key_started;
  esc_phase_t    esc_phase;
  logic [7:0]    held_digit;

  initial begin
    fail_count    = 0;
    words_waiting = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < 50) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    return 5'd0;
  endfunction

  task automatic clear_parse_state();
    in_value    = 1'b0;
    key_started = 1'b0;
    esc_phase   = ESC_NONE;
    held_digit  = 8'h00;
  endtask

  task automatic emit_data(input logic [7:0] b);
    ufp_pkg::res_t r;
    r.kind = in_value ? ufp_pkg::KIND_VAL : ufp_pkg::KIND_KEY;
    r.data = b;
    step_words.push_back(r);
  endtask

  task automatic close_pair();
    ufp_pkg::res_t r;
    r.kind = ufp_pkg::KIND_END;
    r.data = 8'h00;
    step_words.push_back(r);
    in_value    = 1'b0;
    key_started = 1'b0;
  endtask

  task automatic take_plain(input logic [7:0] b);
    logic sep;
    sep = (b == ufp_pkg::CH_AMP) || (b == ufp_pkg::CH_SEMI);
    if (!key_started && sep) return;
    key_started = 1'b1;
    if (sep) begin
      close_pair();
    end else if (b == ufp_pkg::CH_EQ && !in_value) begin
      in_value = 1'b1;
    end else if (b == ufp_pkg::CH_PLUS) begin
      emit_data(ufp_pkg::CH_SPACE);
    end else if (b == ufp_pkg::CH_PCT) begin
      esc_phase = ESC_PCT;
    end else begin
      emit_data(b);
    end
  endtask

  task automatic decode_body_word(input logic is_end, input logic [7:0] b);
    logic [4:0] lo;
    logic [4:0] hi;
    out_word_t  w;
    step_words.delete();
    if (is_end) begin
      if (esc_phase == ESC_PCT) begin
        emit_data(ufp_pkg::CH_PCT);
      end else if (esc_phase == ESC_DIGIT) begin
        emit_data(ufp_pkg::CH_PCT);
        emit_data(held_digit);
      end
      if (key_started) close_pair();
      clear_parse_state();
    end else if (esc_phase == ESC_PCT) begin
      lo = hex_nibble(b);
      if (lo[4]) begin
        held_digit = b;
        esc_phase  = ESC_DIGIT;
      end else begin
        esc_phase = ESC_NONE;
        emit_data(ufp_pkg::CH_PCT);
        take_plain(b);
      end
    end else if (esc_phase == ESC_DIGIT) begin
      lo = hex_nibble(b);
      hi = hex_nibble(held_digit);
      esc_phase = ESC_NONE;
      if (lo[4] && hi[4]) begin
        emit_data({hi[3:0], lo[3:0]});
      end else begin
        emit_data(ufp_pkg::CH_PCT);
        emit_data(held_digit);
        take_plain(b);
      end
      held_digit = 8'h00;
    end else begin
      esc_phase = ESC_NONE;
      take_plain(b);
    end
    foreach (step_words[i]) begin
      w.kind = step_words[i].kind;
      w.data = step_words[i].data;
      w.last = (i == step_words.size() - 1);
      expected_words.push_back(w);
    end
  endtask

  always @(posedge clk) begin : monitor
    out_word_t want;
    if (!rst_n) begin
      clear_parse_state();
      expected_words.delete();
    end else begin
      if (in_push && !in_full) decode_body_word(in_func, in_byte);
      if (out_pop && !out_empty) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d byte %02h last %0b",
                                    out_kind, out_byte, out_last));
        end else begin
          want = expected_words.pop_front();
          if (out_kind !== want.kind || out_byte !== want.data || out_last !== want.last) begin
            report_mismatch($sformatf(
              "word got/expected: kind %0d/%0d byte %02h/%02h last %0b/%0b",
              out_kind, want.kind, out_byte, want.data, out_last, want.last));
          end
        end
      end
    end
    words_waiting <= expected_words.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the form body parser
// Sends a directed body that walks the grammar's corner cases, then random
// bodies built mostly from well-formed pairs with random content. Both sides
// idle at random, and the receiver holds off once long enough to fill the
// parser. A separate scoreboard checks every output word.
// ----------------------------------------------------------------------------
module tb;

  localparam logic FUNC_BODY    = 1'b0;
  localparam logic FUNC_END     = 1'b1;
  localparam int   RANDOM_ITEMS = 140;
  localparam int   IDLE_PCT     = 29;
  localparam int   HOLD_CYCLES  = 80;
  localparam int   DRAIN_CYCLES = 20;

  logic       clk     = 1'b0;
  logic       rst_n   = 1'b0;
  logic       in_push = 1'b0;
  logic       in_func = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       out_pop = 1'b0;
  logic       in_full;
  logic       out_empty;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  int         fail_count;
  int         words_waiting;

  bit hold_req   = 1'b0;
  bit calm       = 1'b0;
  int items_sent = 0;
  int calm_from  = 0;
  int calm_to    = 0;

  urlencoded_form_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_func   (in_func),
    .in_byte   (in_byte),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  form_parse_checker parse_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_func       (in_func),
    .in_byte       (in_byte),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_kind      (out_kind),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .fail_count    (fail_count),
    .words_waiting (words_waiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : receiver
    int held;
    held = 0;
    forever begin
      @(negedge clk);
      if (hold_req && held < HOLD_CYCLES) begin
        out_pop <= 1'b0;
        held++;
      end else begin
        out_pop <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_word(input logic is_end, input logic [7:0] b);
    logic taken;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_func <= is_end;
    in_byte <= b;
    do begin
      @(posedge clk);
      taken = !in_full;
    end while (!taken);
    @(negedge clk);
    items_sent++;
    calm = (items_sent >= calm_from) && (items_sent < calm_to);
  endtask

  task automatic send_end();
    send_word(FUNC_END, 8'($urandom_range(255)));
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_word(FUNC_BODY, s[i]);
  endtask

  function automatic logic [7:0] hex_char();
    int nib;
    nib = $urandom_range(15);
    if (nib < 10) return 8'("0" + nib);
    return 8'(($urandom_range(1) ? "A" : "a") + nib - 10);
  endfunction

  task automatic send_content();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      send_word(FUNC_BODY, 8'($urandom_range(8'h7e, 8'h21)));
    end else if (pick < 62) begin
      send_word(FUNC_BODY, ufp_pkg::CH_PLUS);
    end else if (pick < 85) begin
      send_word(FUNC_BODY, ufp_pkg::CH_PCT);
      send_word(FUNC_BODY, hex_char());
      send_word(FUNC_BODY, hex_char());
    end else if (pick < 92) begin
      send_word(FUNC_BODY, ufp_pkg::CH_PCT);
      if ($urandom_range(1)) send_word(FUNC_BODY, hex_char());
      send_word(FUNC_BODY, 8'($urandom_range(255)));
    end else begin
      send_word(FUNC_BODY, 8'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    int pick;
    int stop_at;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Corner cases: empty body end, skipped separators, empty key, '=' in a
    // value, plus, both hex cases, broken escapes, byte extremes, and an end
    // of body with a half-finished escape.
    send_end();
    send_text("&;=k=v+%4a%6F&");
    send_text("%z%4g");
    send_word(FUNC_BODY, 8'h00);
    send_word(FUNC_BODY, 8'hff);
    send_text("%A");
    send_end();

    hold_req  = 1'b1;
    calm_from = items_sent + 100;
    calm_to   = items_sent + 140;
    stop_at   = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        repeat ($urandom_range(4)) send_content();
        if ($urandom_range(9) != 0) send_word(FUNC_BODY, ufp_pkg::CH_EQ);
        repeat ($urandom_range(4)) send_content();
        pick = $urandom_range(99);
        if (pick < 45) begin
          send_word(FUNC_BODY, ufp_pkg::CH_AMP);
        end else if (pick < 80) begin
          send_word(FUNC_BODY, ufp_pkg::CH_SEMI);
        end else begin
          send_end();
        end
      end else if (pick < 92) begin
        repeat ($urandom_range(3, 1)) send_word(FUNC_BODY, 8'($urandom_range(255)));
      end else begin
        send_end();
      end
    end
    send_end();
    in_push <= 1'b0;

    while (words_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_waiting == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
